// ===== rtl/core/tcst_pkg.sv =====
// Shared constants and types for the touch contact slot table.
// Holds the table size, the event and status codes and the sequencer states.
// No dependencies.
`default_nettype none

package tcst_pkg;

  localparam int SLOTS  = 10;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam int OP_W     = 2;
  localparam int ID_W     = 31;
  localparam int POS_W    = 16;
  localparam int STAMP_W  = 32;
  localparam int OSLOT_W  = 4;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 4;

  localparam logic [OP_W-1:0] OP_DOWN   = 2'd0;
  localparam logic [OP_W-1:0] OP_UP     = 2'd1;
  localparam logic [OP_W-1:0] OP_MOTION = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd2;

  localparam logic [LIVE_W-1:0] LIVE_MAX = 4'd15;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcst_if.sv =====
// Valid/ready channel interfaces for touch events and their results.
// Depends on tcst_pkg for the field widths.
`default_nettype none

interface tcst_in_if;
  logic                             valid;
  logic                             ready;
  logic [tcst_pkg::OP_W-1:0]        op;
  logic [tcst_pkg::ID_W-1:0]        contact_id;
  logic [tcst_pkg::POS_W-1:0]       pos_x;
  logic [tcst_pkg::POS_W-1:0]       pos_y;
  logic [tcst_pkg::STAMP_W-1:0]     stamp_ms;

  modport source (output valid, op, contact_id, pos_x, pos_y, stamp_ms, input ready);
  modport sink (input valid, op, contact_id, pos_x, pos_y, stamp_ms, output ready);
endinterface

interface tcst_out_if;
  logic                             valid;
  logic                             ready;
  logic [tcst_pkg::OSLOT_W-1:0]     slot;
  logic [tcst_pkg::STATUS_W-1:0]    status;
  logic [tcst_pkg::LIVE_W-1:0]      live_count;

  modport source (output valid, slot, status, live_count, input ready);
  modport sink (input valid, slot, status, live_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/touch_contact_slot_table.sv =====
// Touch contact slot table: down, up and motion events against a table of slots.
// Depends on tcst_pkg and the channel interfaces in tcst_if.sv.
//
// Usage:
//   Events enter on in_chan (valid/ready) and each one produces exactly one result
//   item on out_chan carrying the slot, a status and the live contact count.
//   A down event claims the lowest free slot, an up event frees the lowest live
//   slot holding the id, and a motion event rewrites position and time stamp there.
//   After an item is accepted, one comparator walks the slots one per cycle and
//   stops at the first hit or after the last slot. The sequencer then goes to its
//   finish state and loads the result into the output register once the output
//   is free. in_chan.ready is high only in the idle state, so no new item is
//   accepted while one is being scanned or waits in the finish state.
//   The result sits in an output register, so a stalled receiver only delays the
//   next result: one further item is scanned and then waits in the sequencer.
//   Synchronous reset clears all live flags, the count and the output valid flag, and returns the sequencer to idle.
`default_nettype none

module touch_contact_slot_table (
  input  wire              clk,
  input  wire              rst_n,
  tcst_in_if.sink          in_chan,
  tcst_out_if.source       out_chan
);

  localparam int SLOT_W = tcst_pkg::SLOT_W;
  localparam int CNT_W  = tcst_pkg::CNT_W;

  tcst_pkg::state_t state_r, state_nxt;

  logic [tcst_pkg::OP_W-1:0]    op_r;
  logic [tcst_pkg::ID_W-1:0]    id_r;
  logic [tcst_pkg::POS_W-1:0]   x_r;
  logic [tcst_pkg::POS_W-1:0]   y_r;
  logic [tcst_pkg::STAMP_W-1:0] stamp_r;

  logic [SLOT_W-1:0] idx_r;
  logic              found_r;
  logic [SLOT_W-1:0] found_idx_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [tcst_pkg::SLOTS-1:0]   live_r;
  logic [tcst_pkg::ID_W-1:0]    contact_r [tcst_pkg::SLOTS];
  logic [tcst_pkg::POS_W-1:0]   slot_x_r  [tcst_pkg::SLOTS];
  logic [tcst_pkg::POS_W-1:0]   slot_y_r  [tcst_pkg::SLOTS];
  logic [tcst_pkg::STAMP_W-1:0] stamp_tab_r [tcst_pkg::SLOTS];

  logic                          out_valid_r;
  logic [tcst_pkg::OSLOT_W-1:0]  out_slot_r;
  logic [tcst_pkg::STATUS_W-1:0] out_status_r;
  logic [tcst_pkg::LIVE_W-1:0]   out_live_r;

  logic in_fire;
  logic out_free;
  logic scan_en;
  logic finish_en;
  logic last;
  logic hit;
  logic id_eq;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign last     = (idx_r == SLOT_W'(tcst_pkg::SLOTS - 1));
  assign id_eq    = (contact_r[idx_r] == id_r);

  always_comb begin
    unique case (op_r)
      tcst_pkg::OP_DOWN:   hit = !live_r[idx_r];
      tcst_pkg::OP_UP:     hit = live_r[idx_r] && id_eq;
      tcst_pkg::OP_MOTION: hit = live_r[idx_r] && id_eq;
      default:             hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcst_pkg::S_IDLE: begin
        if (in_fire) state_nxt = tcst_pkg::S_SCAN;
      end
      tcst_pkg::S_SCAN: begin
        if (hit || last) state_nxt = tcst_pkg::S_FINISH;
      end
      tcst_pkg::S_FINISH: begin
        if (out_free) state_nxt = tcst_pkg::S_IDLE;
      end
      default: state_nxt = tcst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = 1'b0;
    scan_en       = 1'b0;
    finish_en     = 1'b0;
    unique case (state_r)
      tcst_pkg::S_IDLE:   in_chan.ready = 1'b1;
      tcst_pkg::S_SCAN:   scan_en = 1'b1;
      tcst_pkg::S_FINISH: finish_en = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_chan.op;
      id_r    <= in_chan.contact_id;
      x_r     <= in_chan.pos_x;
      y_r     <= in_chan.pos_y;
      stamp_r <= in_chan.stamp_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (in_fire) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (scan_en) begin
      if (hit) begin
        found_r <= 1'b1;
      end else if (!last) begin
        idx_r <= SLOT_W'(idx_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_en && hit) begin
      found_idx_r <= idx_r;
    end
  end

  // Table updates happen in the scan cycle that finds the slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      cnt_r  <= '0;
    end else if (scan_en && hit) begin
      if (op_r == tcst_pkg::OP_DOWN) begin
        live_r[idx_r] <= 1'b1;
        cnt_r         <= CNT_W'(cnt_r + 1'b1);
      end else if (op_r == tcst_pkg::OP_UP) begin
        live_r[idx_r] <= 1'b0;
        cnt_r         <= CNT_W'(cnt_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_en && hit) begin
      if (op_r == tcst_pkg::OP_DOWN) begin
        contact_r[idx_r] <= id_r;
      end
      if (op_r == tcst_pkg::OP_DOWN || op_r == tcst_pkg::OP_MOTION) begin
        slot_x_r[idx_r]    <= x_r;
        slot_y_r[idx_r]    <= y_r;
        stamp_tab_r[idx_r] <= stamp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish_en) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_en) begin
      out_slot_r <= found_r ? tcst_pkg::OSLOT_W'(found_idx_r) : '0;
      if (found_r) begin
        out_status_r <= tcst_pkg::STAT_OK;
      end else if (op_r == tcst_pkg::OP_DOWN) begin
        out_status_r <= tcst_pkg::STAT_FULL;
      end else begin
        out_status_r <= tcst_pkg::STAT_MISSING;
      end
      out_live_r <= (cnt_r > CNT_W'(tcst_pkg::LIVE_MAX)) ? tcst_pkg::LIVE_MAX
                                                        : tcst_pkg::LIVE_W'(cnt_r);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.slot       = out_slot_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.live_count = out_live_r;

endmodule

`default_nettype wire

// ===== rtl/core/tcst_checker.sv =====
// Port-level checks for the touch contact slot table, bound to the top level.
// Depends on tcst_pkg and touch_contact_slot_table.
`default_nettype none

module tcst_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_valid,
  input wire                               in_ready,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire [tcst_pkg::OSLOT_W-1:0]       out_slot,
  input wire [tcst_pkg::STATUS_W-1:0]      out_status,
  input wire [tcst_pkg::LIVE_W-1:0]        out_live_count
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_status)
      && $stable(out_live_count))
    else $error("result changed while stalled");

  // Ready drops after an item is accepted, so the next one is not taken at once.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted during a scan");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tcst_pkg::STAT_OK |-> out_slot == '0)
    else $error("nonzero slot on a failed event");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == tcst_pkg::STAT_OK || out_status == tcst_pkg::STAT_FULL
      || out_status == tcst_pkg::STAT_MISSING)
    else $error("undefined status code");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_live_count <= tcst_pkg::SLOTS)
    else $error("live count above table size");

endmodule

bind touch_contact_slot_table tcst_checker u_tcst_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_slot       (out_chan.slot),
  .out_status     (out_chan.status),
  .out_live_count (out_chan.live_count)
);

`default_nettype wire

// ===== dv/touch_contact_slot_table_test.sv =====
// Self-checking testbench for the touch contact slot table.
// Drives down, up and motion events and checks each result against a local slot tracker or a fixed expected value.
// Depends on tcst_pkg, the channel interfaces in tcst_if.sv and the block itself.
`timescale 1ns / 100ps

module touch_contact_slot_table_test;

  localparam logic [tcst_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DIRECTED_ROWS = 22;
  localparam int PHASE_EVENTS = 260;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic [tcst_pkg::OP_W-1:0]    op;
    logic [tcst_pkg::ID_W-1:0]    contact_id;
    logic [tcst_pkg::POS_W-1:0]   pos_x;
    logic [tcst_pkg::POS_W-1:0]   pos_y;
    logic [tcst_pkg::STAMP_W-1:0] stamp_ms;
  } touch_event_t;

  typedef struct packed {
    logic [tcst_pkg::OSLOT_W-1:0]  slot;
    logic [tcst_pkg::STATUS_W-1:0] status;
    logic [tcst_pkg::LIVE_W-1:0]   live_count;
  } contact_result_t;

  typedef struct packed {
    logic [tcst_pkg::OP_W-1:0]     op;
    logic [tcst_pkg::ID_W-1:0]     contact_id;
    logic [tcst_pkg::POS_W-1:0]    pos_x;
    logic [tcst_pkg::POS_W-1:0]    pos_y;
    logic [tcst_pkg::STAMP_W-1:0]  stamp_ms;
    logic                          typed;
    logic [tcst_pkg::OSLOT_W-1:0]  slot;
    logic [tcst_pkg::STATUS_W-1:0] status;
    logic [tcst_pkg::LIVE_W-1:0]   live_count;
  } directed_row_t;

  logic clk;
  logic rst_n;

  tcst_in_if  in_chan ();
  tcst_out_if out_chan ();

  touch_contact_slot_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic                         tbl_live  [tcst_pkg::SLOTS];
  logic [tcst_pkg::ID_W-1:0]    tbl_id    [tcst_pkg::SLOTS];
  logic [tcst_pkg::POS_W-1:0]   tbl_x     [tcst_pkg::SLOTS];
  logic [tcst_pkg::POS_W-1:0]   tbl_y     [tcst_pkg::SLOTS];
  logic [tcst_pkg::STAMP_W-1:0] tbl_stamp [tcst_pkg::SLOTS];

  contact_result_t pending_results [$];
  directed_row_t   directed_rows [DIRECTED_ROWS];

  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int stall_cycles;
  int n_down, n_up, n_motion, n_unused;
  int n_ok, n_full, n_missing;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic contact_result_t track_contact(input touch_event_t ev);
    contact_result_t r;
    int hit;
    int live;
    int i;
    hit = -1;
    live = 0;
    r.slot = '0;
    r.status = tcst_pkg::STAT_MISSING;
    case (ev.op)
      tcst_pkg::OP_DOWN: begin
        for (i = 0; i < tcst_pkg::SLOTS; i++)
          if (hit < 0 && !tbl_live[i]) hit = i;
        if (hit < 0) begin
          r.status = tcst_pkg::STAT_FULL;
        end else begin
          tbl_live[hit]  = 1'b1;
          tbl_id[hit]    = ev.contact_id;
          tbl_x[hit]     = ev.pos_x;
          tbl_y[hit]     = ev.pos_y;
          tbl_stamp[hit] = ev.stamp_ms;
        end
      end
      tcst_pkg::OP_UP, tcst_pkg::OP_MOTION: begin
        for (i = 0; i < tcst_pkg::SLOTS; i++)
          if (hit < 0 && tbl_live[i] && tbl_id[i] == ev.contact_id) hit = i;
        if (hit >= 0 && ev.op == tcst_pkg::OP_UP) begin
          tbl_live[hit] = 1'b0;
        end else if (hit >= 0) begin
          tbl_x[hit]     = ev.pos_x;
          tbl_y[hit]     = ev.pos_y;
          tbl_stamp[hit] = ev.stamp_ms;
        end
      end
      default: begin
      end
    endcase
    if (hit >= 0) begin
      r.status = tcst_pkg::STAT_OK;
      r.slot = hit[tcst_pkg::OSLOT_W-1:0];
    end
    for (i = 0; i < tcst_pkg::SLOTS; i++)
      if (tbl_live[i]) live++;
    r.live_count = (live > 15) ? tcst_pkg::LIVE_MAX : live[tcst_pkg::LIVE_W-1:0];
    return r;
  endfunction

  // Mostly well-formed touch traffic on live contacts, with some noise mixed in.
  function automatic touch_event_t random_touch_event();
    touch_event_t ev;
    int live_slots [$];
    int roll;
    int i;
    for (i = 0; i < tcst_pkg::SLOTS; i++)
      if (tbl_live[i]) live_slots.push_back(i);
    ev.pos_x = tcst_pkg::POS_W'($urandom_range(0, 65535));
    ev.pos_y = tcst_pkg::POS_W'($urandom_range(0, 65535));
    ev.stamp_ms = tcst_pkg::STAMP_W'($urandom);
    if ($urandom_range(0, 1) == 0) ev.contact_id = tcst_pkg::ID_W'($urandom_range(0, 15));
    else ev.contact_id = tcst_pkg::ID_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      ev.op = tcst_pkg::OP_DOWN;
    end else if (roll < 90 && live_slots.size() > 0) begin
      ev.op = (roll < 65) ? tcst_pkg::OP_MOTION : tcst_pkg::OP_UP;
      ev.contact_id = tbl_id[live_slots[$urandom_range(0, live_slots.size() - 1)]];
    end else begin
      ev.op = tcst_pkg::OP_W'($urandom_range(0, 3));
    end
    return ev;
  endfunction

  task automatic send_touch_event(input touch_event_t ev, input logic typed,
                                  input contact_result_t want);
    contact_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid      <= 1'b1;
    in_chan.op         <= ev.op;
    in_chan.contact_id <= ev.contact_id;
    in_chan.pos_x      <= ev.pos_x;
    in_chan.pos_y      <= ev.pos_y;
    in_chan.stamp_ms   <= ev.stamp_ms;
    do @(posedge clk); while (!in_chan.ready);
    predicted = track_contact(ev);
    pending_results.push_back(typed ? want : predicted);
    case (ev.op)
      tcst_pkg::OP_DOWN:   n_down++;
      tcst_pkg::OP_UP:     n_up++;
      tcst_pkg::OP_MOTION: n_motion++;
      default:             n_unused++;
    endcase
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    contact_result_t want;
    contact_result_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.slot, out_chan.status, out_chan.live_count};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result slot=%0d status=%0d live=%0d", $time,
                 got.slot, got.status, got.live_count);
      end else begin
        want = pending_results.pop_front();
        if (got.slot != want.slot || got.status != want.status ||
            got.live_count != want.live_count) begin
          errors++;
          $display("%0t: want slot=%0d status=%0d live=%0d, got slot=%0d status=%0d live=%0d",
                   $time, want.slot, want.status, want.live_count,
                   got.slot, got.status, got.live_count);
        end
        case (got.status)
          tcst_pkg::STAT_OK:   n_ok++;
          tcst_pkg::STAT_FULL: n_full++;
          default:             n_missing++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("touch_contact_slot_table_test failed");
        $finish;
      end
    end
  end

  initial begin
    touch_event_t ev;
    contact_result_t want;
    int phase;
    int n;
    clk = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.op = tcst_pkg::OP_DOWN;
    in_chan.contact_id = '0;
    in_chan.pos_x = '0;
    in_chan.pos_y = '0;
    in_chan.stamp_ms = '0;
    out_chan.ready = 1'b0;
    errors = 0;
    stall_cycles = 0;
    n_down = 0; n_up = 0; n_motion = 0; n_unused = 0;
    n_ok = 0; n_full = 0; n_missing = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (n = 0; n < tcst_pkg::SLOTS; n++) begin
      tbl_live[n] = 1'b0;
      tbl_id[n] = '0;
      tbl_x[n] = '0;
      tbl_y[n] = '0;
      tbl_stamp[n] = '0;
    end

    directed_rows = '{
      '{tcst_pkg::OP_UP,     31'd5,         16'd0,    16'd0,    32'd0,
        1'b1, 4'd0, tcst_pkg::STAT_MISSING, 4'd0},
      '{tcst_pkg::OP_MOTION, 31'd5,         16'd1,    16'd1,    32'd1,
        1'b1, 4'd0, tcst_pkg::STAT_MISSING, 4'd0},
      '{OP_UNUSED,           31'd0,         16'd0,    16'd0,    32'd0,
        1'b1, 4'd0, tcst_pkg::STAT_MISSING, 4'd0},
      '{tcst_pkg::OP_DOWN,   31'd0,         16'd0,    16'd0,    32'd0,
        1'b1, 4'd0, tcst_pkg::STAT_OK,      4'd1},
      '{tcst_pkg::OP_DOWN,   31'h7fff_ffff, 16'hffff, 16'hffff, 32'hffff_ffff,
        1'b1, 4'd1, tcst_pkg::STAT_OK,      4'd2},
      '{tcst_pkg::OP_DOWN,   31'd0,         16'h8000, 16'h7fff, 32'h8000_0000,
        1'b1, 4'd2, tcst_pkg::STAT_OK,      4'd3},
      '{tcst_pkg::OP_DOWN,   31'd100,       16'd10,   16'd20,   32'd30,
        1'b1, 4'd3, tcst_pkg::STAT_OK,      4'd4},
      '{tcst_pkg::OP_DOWN,   31'd101,       16'd11,   16'd21,   32'd31,
        1'b1, 4'd4, tcst_pkg::STAT_OK,      4'd5},
      '{tcst_pkg::OP_DOWN,   31'd102,       16'd12,   16'd22,   32'd32,
        1'b1, 4'd5, tcst_pkg::STAT_OK,      4'd6},
      '{tcst_pkg::OP_DOWN,   31'd103,       16'd13,   16'd23,   32'd33,
        1'b1, 4'd6, tcst_pkg::STAT_OK,      4'd7},
      '{tcst_pkg::OP_DOWN,   31'd104,       16'd14,   16'd24,   32'd34,
        1'b1, 4'd7, tcst_pkg::STAT_OK,      4'd8},
      '{tcst_pkg::OP_DOWN,   31'd105,       16'd15,   16'd25,   32'd35,
        1'b1, 4'd8, tcst_pkg::STAT_OK,      4'd9},
      '{tcst_pkg::OP_DOWN,   31'd106,       16'd16,   16'd26,   32'd36,
        1'b1, 4'd9, tcst_pkg::STAT_OK,      4'd10},
      '{tcst_pkg::OP_DOWN,   31'd200,       16'd1,    16'd2,    32'd3,
        1'b1, 4'd0, tcst_pkg::STAT_FULL,    4'd10},
      '{tcst_pkg::OP_MOTION, 31'h7fff_ffff, 16'h1234, 16'h4321, 32'd1000,
        1'b0, 4'd0, tcst_pkg::STAT_OK,      4'd0},
      '{tcst_pkg::OP_UP,     31'd0,         16'd0,    16'd0,    32'd0,
        1'b1, 4'd0, tcst_pkg::STAT_OK,      4'd9},
      '{tcst_pkg::OP_MOTION, 31'd0,         16'h5555, 16'haaaa, 32'd2000,
        1'b0, 4'd0, tcst_pkg::STAT_OK,      4'd0},
      '{tcst_pkg::OP_DOWN,   31'd300,       16'd300,  16'd301,  32'd3000,
        1'b0, 4'd0, tcst_pkg::STAT_OK,      4'd0},
      '{OP_UNUSED,           31'd300,       16'hffff, 16'hffff, 32'hffff_ffff,
        1'b1, 4'd0, tcst_pkg::STAT_MISSING, 4'd10},
      '{tcst_pkg::OP_UP,     31'h7fff_ffff, 16'd0,    16'd0,    32'd0,
        1'b0, 4'd0, tcst_pkg::STAT_OK,      4'd0},
      '{tcst_pkg::OP_UP,     31'h7fff_ffff, 16'd0,    16'd0,    32'd0,
        1'b1, 4'd0, tcst_pkg::STAT_MISSING, 4'd9},
      '{tcst_pkg::OP_UP,     31'd0,         16'd0,    16'd0,    32'd0,
        1'b0, 4'd0, tcst_pkg::STAT_OK,      4'd0}
    };

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < DIRECTED_ROWS; n++) begin
      ev = '{directed_rows[n].op, directed_rows[n].contact_id, directed_rows[n].pos_x,
             directed_rows[n].pos_y, directed_rows[n].stamp_ms};
      want = '{directed_rows[n].slot, directed_rows[n].status, directed_rows[n].live_count};
      send_touch_event(ev, directed_rows[n].typed, want);
    end
    drain_results();

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 14 : 0;
      for (n = 0; n < PHASE_EVENTS; n++) begin
        send_touch_event(random_touch_event(), 1'b0, '0);
        if ($urandom_range(0, 99) == 0) drain_results();
      end
      drain_results();
    end

    repeat (3 * tcst_pkg::SLOTS) @(posedge clk);

    $display("Covered %0d down, %0d up, %0d motion, %0d bad-op events over three idle mixes.",
             n_down, n_up, n_motion, n_unused);
    $display("Results seen: %0d ok, %0d table full, %0d id not found.",
             n_ok, n_full, n_missing);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("touch_contact_slot_table_test passed");
    end else begin
      $display("touch_contact_slot_table_test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tcst_pkg.sv
rtl/core/tcst_if.sv
rtl/core/touch_contact_slot_table.sv
rtl/core/tcst_checker.sv
dv/touch_contact_slot_table_test.sv
